// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, clocked, disabled while reset is low
`define CHK_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication check: when cond holds, prop holds in the same cycle
`define CHK_IMPLY(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error(msg);

`endif

// ===== design/fstf_pkg.sv =====
`default_nettype none
package fstf_pkg;

    localparam int unsigned FIELD_W  = 24;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned TR_W     = 17;
    localparam int unsigned MINEXT_W = 16;
    localparam int unsigned DVD_W    = 41;
    localparam int unsigned DVS_W    = 24;
    localparam int unsigned DCNT_W   = 6;

    localparam logic [MINEXT_W-1:0] MIN_EXT_RESET = 16'd7;
    localparam logic [3:0]          SERIES_TERMS  = 4'd12;
    localparam logic [1:0]          LAST_SQUARING = 2'd3;
    localparam logic [1:0]          LAST_CHANNEL  = 2'd2;
    localparam logic [15:0]         CUTOFF_DEPTH  = 16'd12;
    localparam logic [TR_W-1:0]     ONE_Q16       = 17'd65536;
    localparam logic [31:0]         ONE_Q31       = 32'h8000_0000;
    localparam logic [SUM_W-1:0]    SAT32         = 32'hFFFF_FFFF;

    // one slice as held in the queue
    typedef struct packed {
        logic               first;
        logic               thin;
        logic [FIELD_W-1:0] ext;
        logic [FIELD_W-1:0] thick;
        logic [FIELD_W-1:0] sr;
        logic [FIELD_W-1:0] sg;
        logic [FIELD_W-1:0] sb;
    } item_t;

endpackage
`default_nettype wire

// ===== design/fstf_queue.sv =====
`default_nettype none
`include "assert_macros.svh"
module fstf_queue
    import fstf_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       pop_valid,
    output item_t      pop_item
);

    item_t      q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_item  = q_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= push_item;
        end
    end

    `CHK_ALWAYS(a_count_range, aclk, aresetn, count_reg <= 2'd2, "queue count out of range")
    `CHK_IMPLY(a_no_overflow, aclk, aresetn, push, count_reg != 2'd2, "push into full queue")
    `CHK_IMPLY(a_no_underflow, aclk, aresetn, pop, count_reg != 2'd0, "pop from empty queue")

endmodule
`default_nettype wire

// ===== design/fstf_front.sv =====
`default_nettype none
module fstf_front
    import fstf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [MINEXT_W-1:0] cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_first_slice,
    input  wire logic [FIELD_W-1:0]  s_extinction,
    input  wire logic [FIELD_W-1:0]  s_thickness,
    input  wire logic [FIELD_W-1:0]  s_scatter_red,
    input  wire logic [FIELD_W-1:0]  s_scatter_green,
    input  wire logic [FIELD_W-1:0]  s_scatter_blue,
    input  wire logic                q_full,
    output logic                     q_push,
    output item_t                    q_item
);

    logic [MINEXT_W-1:0] min_ext_reg;

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_ext_reg <= MIN_EXT_RESET;
        end else if (cfg_wr_en) begin
            min_ext_reg <= cfg_wr_data;
        end
    end

    // accept and classify thin or analytic slab
    assign s_ready      = !q_full;
    assign q_push       = s_valid && !q_full;
    assign q_item.first = s_first_slice;
    assign q_item.thin  = (s_extinction <= {8'd0, min_ext_reg});
    assign q_item.ext   = s_extinction;
    assign q_item.thick = s_thickness;
    assign q_item.sr    = s_scatter_red;
    assign q_item.sg    = s_scatter_green;
    assign q_item.sb    = s_scatter_blue;

endmodule
`default_nettype wire

// ===== design/fstf_div.sv =====
`default_nettype none
module fstf_div
    import fstf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  done,
    output logic [DVD_W-1:0]      quotient
);

    logic              busy_reg;
    logic              done_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    rem_reg;
    logic [DVS_W:0]    rem_shift;
    logic              fits;

    assign rem_shift = {rem_reg[DVS_W-1:0], dvd_reg[DVD_W-1]};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});
    assign done      = done_reg;
    assign quotient  = dvd_reg;

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DCNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - DCNT_W'(1);
                if (cnt_reg == DCNT_W'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
            // pulse after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == DCNT_W'(1));
        end
    end

    // remainder and quotient shift
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dvs_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
        end
    end

endmodule
`default_nettype wire

// ===== design/fstf_back.sv =====
`default_nettype none
module fstf_back
    import fstf_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire item_t             q_item,
    output logic                   q_pop,
    output logic                   div_start,
    output logic [DVD_W-1:0]       div_dividend,
    output logic [DVS_W-1:0]       div_divisor,
    input  wire logic              div_done,
    input  wire logic [DVD_W-1:0]  div_quotient,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [SUM_W-1:0]       m_sum_red,
    output logic [SUM_W-1:0]       m_sum_green,
    output logic [SUM_W-1:0]       m_sum_blue,
    output logic [TR_W-1:0]        m_total_transmittance
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEPTH, ST_SER_MUL, ST_SER_DIV, ST_SQ, ST_CH_SET, ST_CH_PROD,
        ST_CH_DIV, ST_ACC_SET, ST_ACC, ST_TR_SET, ST_TR
    } state_t;

    state_t              state_reg;
    logic [31:0]         a_reg;
    logic [31:0]         b_reg;
    logic [63:0]         prod;
    logic                thin_reg;
    logic [FIELD_W-1:0]  ext_reg;
    logic [FIELD_W-1:0]  thick_reg;
    logic [FIELD_W-1:0]  s_reg [3];
    logic [SUM_W-1:0]    light_reg [3];
    logic [TR_W-1:0]     through_reg;
    logic [31:0]         aval_reg;
    logic [31:0]         sum_reg;
    logic [31:0]         r_reg;
    logic [3:0]          i_reg;
    logic [1:0]          sq_reg;
    logic [1:0]          ch_reg;
    logic [SUM_W-1:0]    integ_reg;
    logic                div_start_reg;
    logic [DVD_W-1:0]    div_dvd_reg;
    logic [DVS_W-1:0]    div_dvs_reg;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic [SUM_W-1:0]    out_r_reg;
    logic [SUM_W-1:0]    out_g_reg;
    logic [SUM_W-1:0]    out_b_reg;
    logic [TR_W-1:0]     out_t_reg;

    logic [31:0]         r_round;
    logic [TR_W-1:0]     slab_t;
    logic [31:0]         one_minus;
    logic [31:0]         q32;
    logic [31:0]         ser_term;
    logic [31:0]         ser_sum;
    logic [33:0]         acc_sum;
    logic [SUM_W-1:0]    acc_sat;
    logic [TR_W-1:0]     through_new;
    logic                tr_fire;

    // series index reciprocal, rounded up, exact for terms below 2^31
    function automatic logic [31:0] recip_mult(input logic [3:0] k);
        logic [31:0] m;
        unique case (k)
            4'd3, 4'd6, 4'd12: m = 32'd2863311531;
            4'd5, 4'd10:       m = 32'd3435973837;
            4'd7:              m = 32'd2454267027;
            4'd9:              m = 32'd3817748708;
            4'd11:             m = 32'd3123612579;
            default:           m = ONE_Q31;
        endcase
        return m;
    endfunction

    // extra right shift that goes with the reciprocal
    function automatic logic [2:0] recip_shift(input logic [3:0] k);
        logic [2:0] s;
        unique case (k)
            4'd1:                   s = 3'd0;
            4'd2:                   s = 3'd1;
            4'd3, 4'd4:             s = 3'd2;
            4'd5, 4'd6, 4'd7, 4'd8: s = 3'd3;
            default:                s = 3'd4;
        endcase
        return s;
    endfunction

    // shared multiplier on registered operands
    assign prod = a_reg * b_reg;

    assign r_round     = r_reg + 32'd16384;
    assign slab_t      = r_round[31:15];
    assign one_minus   = ONE_Q31 - r_reg;
    assign q32         = div_quotient[31:0];
    assign ser_term    = prod[62:31] >> recip_shift(i_reg);
    assign ser_sum     = i_reg[0] ? (sum_reg - ser_term) : (sum_reg + ser_term);
    assign acc_sum     = {2'b00, light_reg[ch_reg]} + {1'b0, prod[48:16]};
    assign acc_sat     = (acc_sum[33:32] != 2'b00) ? SAT32 : acc_sum[31:0];
    assign through_new = prod[32:16];

    // result register handshake
    assign tr_fire      = (state_reg == ST_TR) && (!m_valid_reg || m_ready);
    assign m_valid_next = tr_fire || (m_valid_reg && !m_ready);

    assign q_pop        = (state_reg == ST_IDLE) && q_valid;
    assign div_start    = div_start_reg;
    assign div_dividend = div_dvd_reg;
    assign div_divisor  = div_dvs_reg;
    assign m_valid      = m_valid_reg;
    assign m_sum_red    = out_r_reg;
    assign m_sum_green  = out_g_reg;
    assign m_sum_blue   = out_b_reg;
    assign m_total_transmittance = out_t_reg;

    // slice sequencer, accumulators and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            light_reg[0]  <= '0;
            light_reg[1]  <= '0;
            light_reg[2]  <= '0;
            through_reg   <= ONE_Q16;
        end else begin
            m_valid_reg <= m_valid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        thin_reg  <= q_item.thin;
                        ext_reg   <= q_item.ext;
                        thick_reg <= q_item.thick;
                        s_reg[0]  <= q_item.sr;
                        s_reg[1]  <= q_item.sg;
                        s_reg[2]  <= q_item.sb;
                        if (q_item.first) begin
                            light_reg[0] <= '0;
                            light_reg[1] <= '0;
                            light_reg[2] <= '0;
                            through_reg  <= ONE_Q16;
                        end
                        a_reg     <= {8'd0, q_item.ext};
                        b_reg     <= {8'd0, q_item.thick};
                        state_reg <= ST_DEPTH;
                    end
                end
                ST_DEPTH: begin
                    ch_reg <= 2'd0;
                    if (prod[47:32] >= CUTOFF_DEPTH) begin
                        r_reg     <= '0;
                        state_reg <= ST_CH_SET;
                    end else begin
                        aval_reg  <= prod[36:5];
                        sum_reg   <= ONE_Q31;
                        i_reg     <= 4'd1;
                        a_reg     <= ONE_Q31;
                        b_reg     <= prod[36:5];
                        state_reg <= ST_SER_MUL;
                    end
                end
                ST_SER_MUL: begin
                    a_reg     <= prod[62:31];
                    b_reg     <= recip_mult(i_reg);
                    state_reg <= ST_SER_DIV;
                end
                ST_SER_DIV: begin
                    sum_reg <= ser_sum;
                    if (i_reg == SERIES_TERMS) begin
                        a_reg     <= ser_sum;
                        b_reg     <= ser_sum;
                        sq_reg    <= 2'd0;
                        state_reg <= ST_SQ;
                    end else begin
                        i_reg     <= i_reg + 4'd1;
                        a_reg     <= ser_term;
                        b_reg     <= aval_reg;
                        state_reg <= ST_SER_MUL;
                    end
                end
                ST_SQ: begin
                    if (sq_reg == LAST_SQUARING) begin
                        r_reg     <= prod[62:31];
                        state_reg <= ST_CH_SET;
                    end else begin
                        a_reg  <= prod[62:31];
                        b_reg  <= prod[62:31];
                        sq_reg <= sq_reg + 2'd1;
                    end
                end
                ST_CH_SET: begin
                    a_reg     <= {8'd0, s_reg[ch_reg]};
                    b_reg     <= thin_reg ? {8'd0, thick_reg} : one_minus;
                    state_reg <= ST_CH_PROD;
                end
                ST_CH_PROD: begin
                    if (thin_reg) begin
                        integ_reg <= prod[47:16];
                        state_reg <= ST_ACC_SET;
                    end else begin
                        div_dvd_reg   <= prod[55:15];
                        div_dvs_reg   <= ext_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_CH_DIV;
                    end
                end
                ST_CH_DIV: begin
                    div_start_reg <= 1'b0;
                    if (div_done) begin
                        integ_reg <= (div_quotient[DVD_W-1:32] != '0) ? SAT32 : q32;
                        state_reg <= ST_ACC_SET;
                    end
                end
                ST_ACC_SET: begin
                    a_reg     <= {15'd0, through_reg};
                    b_reg     <= integ_reg;
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    light_reg[ch_reg] <= acc_sat;
                    if (ch_reg == LAST_CHANNEL) begin
                        state_reg <= ST_TR_SET;
                    end else begin
                        ch_reg    <= ch_reg + 2'd1;
                        state_reg <= ST_CH_SET;
                    end
                end
                ST_TR_SET: begin
                    a_reg     <= {15'd0, through_reg};
                    b_reg     <= {15'd0, slab_t};
                    state_reg <= ST_TR;
                end
                ST_TR: begin
                    if (tr_fire) begin
                        through_reg <= through_new;
                        out_r_reg   <= light_reg[0];
                        out_g_reg   <= light_reg[1];
                        out_b_reg   <= light_reg[2];
                        out_t_reg   <= through_new;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== design/fog_slice_front_to_back_integrator_top.sv =====
`default_nettype none
// Front-to-back fog slab integrator. Slices enter through a two-item queue and a
// sequencer with one shared 32x32 multiplier works them out one at a time; the
// exponential series divides by its term index through a reciprocal multiply, and a
// one-bit-per-cycle 41-bit divider serves the colour divisions. A slab past the
// cutoff depth skips the series; a slab below it runs twelve series terms and then
// four squarings. A slab on the analytic path adds three colour divisions on the
// divider. The result waits in an output register while the next slice is
// already being worked. The user must write the threshold with cfg_wr_en only
// while the block is idle; the block itself does not enforce this.
module fog_slice_front_to_back_integrator_top
    import fstf_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [MINEXT_W-1:0] cfg_wr_data,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic                s_first_slice,
    input  wire logic [FIELD_W-1:0]  s_extinction,
    input  wire logic [FIELD_W-1:0]  s_thickness,
    input  wire logic [FIELD_W-1:0]  s_scatter_red,
    input  wire logic [FIELD_W-1:0]  s_scatter_green,
    input  wire logic [FIELD_W-1:0]  s_scatter_blue,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [SUM_W-1:0]         m_sum_red,
    output logic [SUM_W-1:0]         m_sum_green,
    output logic [SUM_W-1:0]         m_sum_blue,
    output logic [TR_W-1:0]          m_total_transmittance
);

    logic             q_full;
    logic             q_push;
    item_t            q_in;
    logic             q_pop;
    logic             q_valid;
    item_t            q_out;
    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DVS_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quotient;

    // front: accept and classify
    fstf_front u_front (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .s_valid, .s_ready, .s_first_slice, .s_extinction, .s_thickness,
        .s_scatter_red, .s_scatter_green, .s_scatter_blue,
        .q_full, .q_push, .q_item(q_in)
    );

    // decoupling queue
    fstf_queue u_queue (
        .aclk, .aresetn, .push(q_push), .push_item(q_in), .full(q_full),
        .pop(q_pop), .pop_valid(q_valid), .pop_item(q_out)
    );

    // shared divider
    fstf_div u_div (
        .aclk, .aresetn, .start(div_start), .dividend(div_dividend),
        .divisor(div_divisor), .done(div_done), .quotient(div_quotient)
    );

    // back: integration sequencer
    fstf_back u_back (
        .aclk, .aresetn, .q_valid, .q_item(q_out), .q_pop,
        .div_start, .div_dividend, .div_divisor, .div_done, .div_quotient,
        .m_valid, .m_ready, .m_sum_red, .m_sum_green, .m_sum_blue,
        .m_total_transmittance
    );

endmodule
`default_nettype wire
